FILE: design/agc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_pkg: shared types and constants for the asymmetric Gaussian cost block
// Fixed-point formats, CORDIC arctangent table, exp series reciprocals and
// the structs that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package agc_pkg;

  // Field widths
  localparam int POS_W  = 24;   // Q12.12 positions
  localparam int HEAD_W = 15;   // Q3.12 heading
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;
  localparam int COST_W = 16;

  // Format constants
  localparam int POS_FRAC_BITS = 12;
  localparam int SIG_FRAC_BITS = 12;
  localparam int PRE_BITS      = 8;    // offsets and heading scaled by 256
  localparam int CORDIC_STAGES = 16;
  localparam int RATIO_SHIFT   = SIG_FRAC_BITS + 16 - PRE_BITS - POS_FRAC_BITS;

  // Internal widths
  localparam int DW = POS_W + 1;       // position difference
  localparam int CW = 36;              // CORDIC x/y
  localparam int ZW = 24;              // CORDIC angle, 20 fraction bits
  localparam int AW = 26;              // offset angle before wrapping
  localparam int DIV_BITS = 25;        // ratio quotient bits, capped at 2^24
  localparam int EXP_TERMS = 12;

  localparam logic signed [ZW-1:0] PI_Q      = 24'sd3294199;
  localparam logic signed [ZW-1:0] HALF_PI_Q = 24'sd1647099;
  localparam logic signed [AW-1:0] PI_A      = 26'sd3294199;
  localparam logic signed [AW-1:0] TWO_PI_A  = 26'sd6588397;
  localparam logic signed [17:0]   INV_GAIN  = 18'sd39797;
  localparam logic [31:0]          LN2_Q32   = 32'd2977044472;
  localparam logic [12:0]          LN2_RECIP = 13'd5909;   // floor(2^44 / LN2_Q32)

  typedef enum logic [IDX_W-1:0] {
    REG_AMPLITUDE   = 2'd0,
    REG_SIGMA_FRONT = 2'd1,
    REG_SIGMA_SIDE  = 2'd2,
    REG_SIGMA_REAR  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] amplitude;
    logic [CFG_W-1:0] sigma_front;
    logic [CFG_W-1:0] sigma_side;
    logic [CFG_W-1:0] sigma_rear;
  } agc_cfg_t;

  // Rotated offset scaled by the inverse CORDIC gain, plus side selection
  typedef struct packed {
    logic signed [CW-1:0] pp;
    logic signed [CW-1:0] qq;
    logic                 rear;
  } agc_geo_t;

  typedef struct packed {
    logic              rear_side;
    logic [COST_W-1:0] cost;
  } agc_res_t;

  // round(atan(2^-i) * 2^20)
  function automatic logic signed [ZW-1:0] atan_step(input int unsigned i);
    case (i)
      0:  return 24'sd823550;
      1:  return 24'sd486170;
      2:  return 24'sd256879;
      3:  return 24'sd130396;
      4:  return 24'sd65451;
      5:  return 24'sd32757;
      6:  return 24'sd16383;
      7:  return 24'sd8192;
      8:  return 24'sd4096;
      9:  return 24'sd2048;
      10: return 24'sd1024;
      11: return 24'sd512;
      12: return 24'sd256;
      13: return 24'sd128;
      14: return 24'sd64;
      15: return 24'sd32;
      16: return 24'sd16;
      17: return 24'sd8;
      18: return 24'sd4;
      19: return 24'sd2;
      20: return 24'sd1;
      default: return '0;
    endcase
  endfunction

  // floor(2^32 / k) for the series divisors
  function automatic logic [32:0] exp_recip(input int unsigned k);
    case (k)
      1:  return 33'd4294967296;
      2:  return 33'd2147483648;
      3:  return 33'd1431655765;
      4:  return 33'd1073741824;
      5:  return 33'd858993459;
      6:  return 33'd715827882;
      7:  return 33'd613566756;
      8:  return 33'd536870912;
      9:  return 33'd477218588;
      10: return 33'd429496729;
      11: return 33'd390451572;
      12: return 33'd357913941;
      default: return '0;
    endcase
  endfunction

endpackage

FILE: design/agc_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_geom: offset angle and heading-frame rotation
// Two CORDICs run side by side, one iteration per stage: vectoring for the
// offset angle, rotation by minus heading for the along/side parts.
// ----------------------------------------------------------------------------
module agc_geom (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic signed [agc_pkg::DW-1:0]       dx_i,
  input  logic signed [agc_pkg::DW-1:0]       dy_i,
  input  logic signed [agc_pkg::HEAD_W-1:0]   head_i,
  output logic                                vld_o,
  output agc_pkg::agc_geo_t                   geo_o
);

  localparam int CW  = agc_pkg::CW;
  localparam int ZW  = agc_pkg::ZW;
  localparam int AW  = agc_pkg::AW;
  localparam int DW  = agc_pkg::DW;
  localparam int HW  = agc_pkg::HEAD_W;
  localparam int PB  = agc_pkg::PRE_BITS;
  localparam int NIT = agc_pkg::CORDIC_STAGES;
  localparam int NST = NIT + 3;
  localparam int PW  = CW + 18;

  typedef struct packed {
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic signed [ZW-1:0] vz;
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
    logic signed [ZW-1:0] rz;
    logic signed [ZW-1:0] hz;
    logic                 zero;
  } crd_t;

  logic [NST-1:0] vld_q;
  crd_t           crd_d;
  crd_t           crd_q [NIT+1];

  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] hz, zr;

  // Valid bits follow the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], vld_i};
    end
  end

  // Prescale and fold both CORDICs into their convergence range
  always_comb begin
    xs = {{(CW-DW-PB){dx_i[DW-1]}}, dx_i, {PB{1'b0}}};
    ys = {{(CW-DW-PB){dy_i[DW-1]}}, dy_i, {PB{1'b0}}};
    hz = {{(ZW-HW-PB){head_i[HW-1]}}, head_i, {PB{1'b0}}};
    zr = -hz;
    crd_d      = '0;
    crd_d.hz   = hz;
    crd_d.zero = (dx_i == '0) && (dy_i == '0);
    if (xs < 0) begin
      crd_d.vz = (ys >= 0) ? agc_pkg::PI_Q : -agc_pkg::PI_Q;
      crd_d.vx = -xs;
      crd_d.vy = -ys;
    end else begin
      crd_d.vz = '0;
      crd_d.vx = xs;
      crd_d.vy = ys;
    end
    if (zr > agc_pkg::HALF_PI_Q) begin
      crd_d.rx = -xs;
      crd_d.ry = -ys;
      crd_d.rz = zr - agc_pkg::PI_Q;
    end else if (zr < -agc_pkg::HALF_PI_Q) begin
      crd_d.rx = -xs;
      crd_d.ry = -ys;
      crd_d.rz = zr + agc_pkg::PI_Q;
    end else begin
      crd_d.rx = xs;
      crd_d.ry = ys;
      crd_d.rz = zr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      crd_q[0] <= crd_d;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < NIT; i++) begin : g_it
    crd_t nx;
    always_comb begin
      nx = crd_q[i];
      if (crd_q[i].vy >= 0) begin
        nx.vx = crd_q[i].vx + (crd_q[i].vy >>> i);
        nx.vy = crd_q[i].vy - (crd_q[i].vx >>> i);
        nx.vz = crd_q[i].vz + agc_pkg::atan_step(i);
      end else begin
        nx.vx = crd_q[i].vx - (crd_q[i].vy >>> i);
        nx.vy = crd_q[i].vy + (crd_q[i].vx >>> i);
        nx.vz = crd_q[i].vz - agc_pkg::atan_step(i);
      end
      if (crd_q[i].rz >= 0) begin
        nx.rx = crd_q[i].rx - (crd_q[i].ry >>> i);
        nx.ry = crd_q[i].ry + (crd_q[i].rx >>> i);
        nx.rz = crd_q[i].rz - agc_pkg::atan_step(i);
      end else begin
        nx.rx = crd_q[i].rx + (crd_q[i].ry >>> i);
        nx.ry = crd_q[i].ry - (crd_q[i].rx >>> i);
        nx.rz = crd_q[i].rz + agc_pkg::atan_step(i);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        crd_q[i+1] <= nx;
      end
    end
  end

  // Gain correction products and raw offset angle
  logic signed [PW-1:0] pm_q, qm_q;
  logic signed [AW-1:0] ar_d, ar_q;
  logic signed [ZW-1:0] vz_e;

  always_comb begin
    vz_e = crd_q[NIT].zero ? '0 : crd_q[NIT].vz;
    ar_d = AW'(vz_e) - AW'(crd_q[NIT].hz) + AW'(agc_pkg::HALF_PI_Q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pm_q <= PW'(crd_q[NIT].rx) * PW'(agc_pkg::INV_GAIN);
      qm_q <= PW'(crd_q[NIT].ry) * PW'(agc_pkg::INV_GAIN);
      ar_q <= ar_d;
    end
  end

  // Wrap angle into (-pi, pi] and pick the side
  logic signed [AW-1:0] aw;
  agc_pkg::agc_geo_t    geo_d, geo_q;

  always_comb begin
    aw = ar_q;
    if (aw > agc_pkg::PI_A) aw = aw - agc_pkg::TWO_PI_A;
    if (aw > agc_pkg::PI_A) aw = aw - agc_pkg::TWO_PI_A;
    if (aw <= -agc_pkg::PI_A) aw = aw + agc_pkg::TWO_PI_A;
    if (aw <= -agc_pkg::PI_A) aw = aw + agc_pkg::TWO_PI_A;
    geo_d.pp   = pm_q[CW+15:16];
    geo_d.qq   = qm_q[CW+15:16];
    geo_d.rear = (aw <= 0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo_q <= geo_d;
    end
  end

  assign vld_o = vld_q[NST-1];
  assign geo_o = geo_q;

endmodule

FILE: design/agc_expo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_expo: normalized distance and Gaussian falloff
// Pipelined restoring division by the sigmas, squared sum, range reduction
// by ln2 and a twelve-term series for exp(-r), then amplitude scaling.
// ----------------------------------------------------------------------------
module agc_expo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  agc_pkg::agc_geo_t  geo_i,
  input  agc_pkg::agc_cfg_t  cfg_i,
  output logic               vld_o,
  output agc_pkg::agc_res_t  res_o
);

  localparam int CW  = agc_pkg::CW;
  localparam int DB  = agc_pkg::DIV_BITS;
  localparam int NW  = CW + agc_pkg::RATIO_SHIFT;
  localparam int NT  = agc_pkg::EXP_TERMS;
  localparam int NST = 1 + DB + 5 + 3 * NT + 2;
  localparam logic [DB-1:0] RATIO_CAP = DB'(1 << 24);

  typedef struct packed {
    logic [15:0]   rem;
    logic [DB-1:0] num;
    logic [DB-1:0] quo;
    logic          ovf;
    logic [15:0]   sig;
  } div_t;

  typedef struct packed {
    logic [30:0] t;
    logic [30:0] s;
    logic [31:0] r;
    logic [30:0] v;
    logic [63:0] pr;
    logic [4:0]  n;
    logic        zero;
    logic        rear;
  } ser_t;

  function automatic div_t div_init(input logic signed [CW-1:0] part,
                                    input logic [15:0] sigma);
    logic [CW-1:0] mag;
    logic [NW-1:0] num;
    div_t          o;
    mag   = part[CW-1] ? CW'(-part) : CW'(part);
    num   = {mag, {agc_pkg::RATIO_SHIFT{1'b0}}};
    o.sig = (sigma == '0) ? 16'd1 : sigma;
    o.ovf = num[NW-1:DB] >= (NW-DB)'(o.sig);
    o.rem = num[DB+15:DB];
    o.num = num[DB-1:0];
    o.quo = '0;
    return o;
  endfunction

  function automatic div_t div_step(input div_t d);
    logic [16:0] acc;
    div_t        o;
    o     = d;
    acc   = {d.rem, d.num[DB-1]};
    o.num = d.num << 1;
    if (acc >= {1'b0, d.sig}) begin
      o.rem = 16'(acc - {1'b0, d.sig});
      o.quo = {d.quo[DB-2:0], 1'b1};
    end else begin
      o.rem = acc[15:0];
      o.quo = {d.quo[DB-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [DB-1:0] ratio_cap(input div_t d);
    return (d.ovf || (d.quo > RATIO_CAP)) ? RATIO_CAP : d.quo;
  endfunction

  logic [NST-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], vld_i};
    end
  end

  // Division setup: magnitude, sigma select, overflow check
  div_t        dp_q [DB+1];
  div_t        dq_q [DB+1];
  logic [DB:0] rr_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dp_q[0] <= div_init(geo_i.pp, geo_i.rear ? cfg_i.sigma_rear : cfg_i.sigma_front);
      dq_q[0] <= div_init(geo_i.qq, cfg_i.sigma_side);
      rr_q[0] <= geo_i.rear;
    end
  end

  // One quotient bit per stage
  for (genvar i = 0; i < DB; i++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dp_q[i+1] <= div_step(dp_q[i]);
        dq_q[i+1] <= div_step(dq_q[i]);
        rr_q[i+1] <= rr_q[i];
      end
    end
  end

  // Squares of the capped ratios
  logic [2*DB-1:0] sp_q, sq_q;
  logic            rs_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp_q <= (2*DB)'(ratio_cap(dp_q[DB])) * (2*DB)'(ratio_cap(dp_q[DB]));
      sq_q <= (2*DB)'(ratio_cap(dq_q[DB])) * (2*DB)'(ratio_cap(dq_q[DB]));
      rs_q <= rr_q[DB];
    end
  end

  // Exponent E in Q32, limit check
  logic [2*DB:0] esum;
  logic [35:0]   e_q;
  logic          ez_q, er_q;

  assign esum = {1'b0, sp_q} + {1'b0, sq_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q  <= esum[36:1];
      ez_q <= |esum[2*DB:37];
      er_q <= rs_q;
    end
  end

  // Estimate n = E / ln2 by reciprocal, low by at most one
  logic [28:0] nprod;
  logic [4:0]  n0_q;
  logic [35:0] e1_q;
  logic        z1_q, r1_q;

  assign nprod = 29'(e_q[35:20]) * 29'(agc_pkg::LN2_RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n0_q <= nprod[28:24];
      e1_q <= e_q;
      z1_q <= ez_q;
      r1_q <= er_q;
    end
  end

  // Remainder against the estimate
  logic [36:0] r0;
  logic [32:0] r0_q;
  logic [4:0]  n1_q;
  logic        z2_q, r2_q;

  assign r0 = 37'(e1_q) - 37'(n0_q) * 37'(agc_pkg::LN2_Q32);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r0_q <= r0[32:0];
      n1_q <= n0_q;
      z2_q <= z1_q;
      r2_q <= r1_q;
    end
  end

  // Final correction of n and r, series start at 1.0
  ser_t        ser_d;
  ser_t        ser_q [3*NT+1];
  logic        rge;
  logic [32:0] rsub;

  always_comb begin
    rge        = r0_q >= 33'(agc_pkg::LN2_Q32);
    rsub       = r0_q - 33'(agc_pkg::LN2_Q32);
    ser_d      = '0;
    ser_d.t    = 31'(1 << 30);
    ser_d.s    = 31'(1 << 30);
    ser_d.r    = rge ? rsub[31:0] : r0_q[31:0];
    ser_d.n    = rge ? 5'(n1_q + 5'd1) : n1_q;
    ser_d.zero = z2_q;
    ser_d.rear = r2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ser_q[0] <= ser_d;
    end
  end

  // Each term: t*r, divide by k via reciprocal, correct and accumulate
  for (genvar k = 0; k < NT; k++) begin : g_term
    localparam logic [4:0] KV = 5'(k + 1);
    ser_t        sa, sb, sc;
    logic [30:0] vb, q0;
    logic [34:0] rem;
    logic [30:0] tn;

    always_comb begin
      sa    = ser_q[3*k];
      sa.pr = 64'(ser_q[3*k].t) * 64'(ser_q[3*k].r);
    end

    always_comb begin
      vb    = ser_q[3*k+1].pr[62:32];
      sb    = ser_q[3*k+1];
      sb.v  = vb;
      sb.pr = 64'(vb) * 64'(agc_pkg::exp_recip(k + 1));
    end

    always_comb begin
      q0   = ser_q[3*k+2].pr[62:32];
      rem  = 35'(ser_q[3*k+2].v) - 35'(q0) * 35'(KV);
      tn   = (rem[4:0] >= KV) ? 31'(q0 + 31'd1) : q0;
      sc   = ser_q[3*k+2];
      sc.t = tn;
      sc.s = KV[0] ? 31'(ser_q[3*k+2].s - tn) : 31'(ser_q[3*k+2].s + tn);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ser_q[3*k+1] <= sa;
        ser_q[3*k+2] <= sb;
        ser_q[3*k+3] <= sc;
      end
    end
  end

  // Amplitude scaling with rounding shift by 30 + n
  logic [46:0] ms_q;
  logic [5:0]  sh_q;
  logic        fz_q, fr_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ms_q <= 47'(cfg_i.amplitude) * 47'(ser_q[3*NT].s);
      sh_q <= 6'd30 + 6'(ser_q[3*NT].n);
      fz_q <= ser_q[3*NT].zero;
      fr_q <= ser_q[3*NT].rear;
    end
  end

  logic [53:0]       rsum, rsh;
  agc_pkg::agc_res_t res_d, res_q;

  always_comb begin
    rsum            = 54'(ms_q) + (54'(1) << (sh_q - 6'd1));
    rsh             = rsum >> sh_q;
    res_d.cost      = fz_q ? '0 : rsh[15:0];
    res_d.rear_side = fr_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign vld_o = vld_q[NST-1];
  assign res_o = res_q;

endmodule

FILE: design/asymmetric_gaussian_cost.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asymmetric_gaussian_cost: streaming asymmetric 2-D Gaussian cost
// Takes one cell/person request per clock and returns one cost per request
// in order. The path is one input register, 19 stages of paired CORDICs
// (16 iterations), 69 stages for the 25-bit ratio division, the ln2 range
// reduction and the twelve-term exp series (three stages per term), and
// the output register. Throughput is one request per cycle; a one-entry
// skid stage behind the output register lets one more result land while the
// output is stalled, after which s_axis_tready drops until it drains.
// Configuration writes take effect at once and belong to idle periods.
// ----------------------------------------------------------------------------
module asymmetric_gaussian_cost (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Request stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [23:0] cell_x, [47:24] cell_y, [71:48] center_x, [95:72] center_y,
  // [110:96] heading, [111] zero
  input  logic [111:0]               s_axis_tdata,
  // Result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [15:0] cost, [16] rear_side, [23:17] zero
  output logic [23:0]                m_axis_tdata,
  // Register writes
  input  logic                       cfg_we_i,
  input  logic [agc_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [agc_pkg::CFG_W-1:0]  cfg_wdata_i
);

  localparam int DW = agc_pkg::DW;
  localparam int HW = agc_pkg::HEAD_W;

  agc_pkg::agc_cfg_t cfg_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.amplitude   <= 16'd256;
      cfg_q.sigma_front <= 16'd4096;
      cfg_q.sigma_side  <= 16'd4096;
      cfg_q.sigma_rear  <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        agc_pkg::REG_AMPLITUDE:   cfg_q.amplitude   <= cfg_wdata_i;
        agc_pkg::REG_SIGMA_FRONT: cfg_q.sigma_front <= cfg_wdata_i;
        agc_pkg::REG_SIGMA_SIDE:  cfg_q.sigma_side  <= cfg_wdata_i;
        agc_pkg::REG_SIGMA_REAR:  cfg_q.sigma_rear  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic pipe_en;
  logic skd_v_q, out_v_q;

  // Pipeline advances unless the skid entry is occupied
  assign pipe_en       = !skd_v_q;
  assign s_axis_tready = pipe_en;

  // Input stage: offsets from the person
  logic [23:0]            cell_x, cell_y, ctr_x, ctr_y;
  logic signed [DW-1:0]   dx_q, dy_q;
  logic signed [HW-1:0]   hd_q;
  logic                   in_v_q;

  assign cell_x = s_axis_tdata[23:0];
  assign cell_y = s_axis_tdata[47:24];
  assign ctr_x  = s_axis_tdata[71:48];
  assign ctr_y  = s_axis_tdata[95:72];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (pipe_en) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dx_q <= {cell_x[23], cell_x} - {ctr_x[23], ctr_x};
      dy_q <= {cell_y[23], cell_y} - {ctr_y[23], ctr_y};
      hd_q <= s_axis_tdata[110:96];
    end
  end

  logic              geo_v, res_v;
  agc_pkg::agc_geo_t geo;
  agc_pkg::agc_res_t res;

  agc_geom u_geom (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (in_v_q),
    .dx_i   (dx_q),
    .dy_i   (dy_q),
    .head_i (hd_q),
    .vld_o  (geo_v),
    .geo_o  (geo)
  );

  agc_expo u_expo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (geo_v),
    .geo_i  (geo),
    .cfg_i  (cfg_q),
    .vld_o  (res_v),
    .res_o  (res)
  );

  // Output register with one skid entry
  agc_pkg::agc_res_t out_q, skd_q;
  logic              pop, push;

  assign pop  = out_v_q && m_axis_tready;
  assign push = pipe_en && res_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      skd_v_q <= 1'b0;
    end else if (skd_v_q) begin
      if (pop) skd_v_q <= 1'b0;
    end else if (push) begin
      if (!out_v_q || pop) out_v_q <= 1'b1;
      else                 skd_v_q <= 1'b1;
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skd_v_q) begin
      if (pop) out_q <= skd_q;
    end else if (push) begin
      if (!out_v_q || pop) out_q <= res;
      else                 skd_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, out_q.rear_side, out_q.cost};

endmodule

FILE: design/agc_sva.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_sva: port-level checks for asymmetric_gaussian_cost
// Watches the streams and register writes; bound to the top level.
// ----------------------------------------------------------------------------
module agc_sva (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [23:0]                m_axis_tdata,
  input logic                       cfg_we_i,
  input logic [agc_pkg::IDX_W-1:0]  cfg_idx_i,
  input logic [agc_pkg::CFG_W-1:0]  cfg_wdata_i
);

  logic [agc_pkg::CFG_W-1:0] amp_q;

  // Shadow of the amplitude register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q <= 16'd256;
    end else if (cfg_we_i && (cfg_idx_i == agc_pkg::REG_AMPLITUDE)) begin
      amp_q <= cfg_wdata_i;
    end
  end

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Cost never exceeds the peak
  a_cost_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:0] <= amp_q))
    else $error("cost above amplitude");

  // Backpressure only while a result is waiting
  a_bp_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // Ready drops only after a stalled output
  a_bp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // Padding bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[23:17] == 7'd0))
    else $error("result padding not zero");

endmodule

bind asymmetric_gaussian_cost agc_sva u_agc_sva (.*);

FILE: tb/sv/asymmetric_gaussian_cost_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asymmetric_gaussian_cost_test: self-checking bench for the Gaussian cost
// Streams cell/person requests through the block under several register
// settings, with random gaps on the request side and random stalls on the
// result side. A bit-exact cost predictor queues the expected result of each
// accepted request, and every returned result is checked against it in order.
// ----------------------------------------------------------------------------
module asymmetric_gaussian_cost_test;
  import agc_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int LATENCY     = 90;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [15:0] cost;
    logic        rear;
  } cost_res_t;

  // Cost predictor and in-order store of expected results
  class cost_scoreboard;
    longint unsigned amp, sig_front, sig_side, sig_rear;
    cost_res_t       pending_q[$];
    int              errors;

    function new();
      amp = 256; sig_front = 4096; sig_side = 4096; sig_rear = 4096;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [15:0] v);
      case (idx)
        REG_AMPLITUDE:   amp = v;
        REG_SIGMA_FRONT: sig_front = v;
        REG_SIGMA_SIDE:  sig_side = v;
        REG_SIGMA_REAR:  sig_rear = v;
        default: ;
      endcase
    endfunction

    function longint atan_tab(int i);
      longint t[16] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                        4096, 2048, 1024, 512, 256, 128, 64, 32};
      return t[i];
    endfunction

    // vectoring CORDIC: angle of (x,y), 20 fraction bits
    function longint offset_angle(longint x, longint y);
      longint z, sx, sy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? 3294199 : -3294199;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        sx = x >>> i;
        sy = y >>> i;
        if (y >= 0) begin
          x += sy; y -= sx; z += atan_tab(i);
        end else begin
          x -= sy; y += sx; z -= atan_tab(i);
        end
      end
      return z;
    endfunction

    // rotation CORDIC by z, result still carries the CORDIC gain
    function void rotate_by(longint x, longint y, longint z, output longint ox,
                            output longint oy);
      longint sx, sy;
      if (z > 1647099) begin
        x = -x; y = -y; z -= 3294199;
      end else if (z < -1647099) begin
        x = -x; y = -y; z += 3294199;
      end
      for (int i = 0; i < 16; i++) begin
        sx = x >>> i;
        sy = y >>> i;
        if (z >= 0) begin
          x -= sy; y += sx; z -= atan_tab(i);
        end else begin
          x += sy; y -= sx; z += atan_tab(i);
        end
      end
      ox = x;
      oy = y;
    endfunction

    function longint unsigned spread_ratio(longint part, longint unsigned sigma);
      longint unsigned mag, r;
      mag = (part < 0) ? longint'(-part) : longint'(part);
      if (sigma == 0) sigma = 1;
      r = (mag << 8) / sigma;
      return (r > (64'd1 << 24)) ? (64'd1 << 24) : r;
    endfunction

    // amplitude * exp(-e), e in Q32
    function logic [15:0] scaled_exp(longint unsigned e);
      longint unsigned n, r, t, s;
      int sh;
      if (e >= (64'd16 << 32)) return 16'd0;
      n = e / 64'd2977044472;
      r = e - n * 64'd2977044472;
      t = 64'd1 << 30;
      s = 64'd1 << 30;
      for (int k = 1; k <= 12; k++) begin
        t = ((t * r) >> 32) / k;
        if (k % 2 == 1) s -= t;
        else s += t;
      end
      sh = 30 + int'(n);
      return 16'((amp * s + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function void note_request(logic [23:0] cx, logic [23:0] cy, logic [23:0] px,
                               logic [23:0] py, logic [14:0] hd);
      longint dx, dy, h, alpha, p, q, pp, qq;
      longint unsigned rp, rq;
      cost_res_t res;
      dx = longint'($signed(cx)) - longint'($signed(px));
      dy = longint'($signed(cy)) - longint'($signed(py));
      h  = longint'($signed(hd)) * 256;
      alpha = offset_angle(dx * 256, dy * 256) - h + 1647099;
      while (alpha > 3294199) alpha -= 6588397;
      while (alpha <= -3294199) alpha += 6588397;
      res.rear = (alpha <= 0);
      rotate_by(dx * 256, dy * 256, -h, p, q);
      pp = (p * 39797) >>> 16;
      qq = (q * 39797) >>> 16;
      rp = spread_ratio(pp, res.rear ? sig_rear : sig_front);
      rq = spread_ratio(qq, sig_side);
      res.cost = scaled_exp((rp * rp + rq * rq) >> 1);
      pending_q = {pending_q, res};
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [23:0] data);
      cost_res_t want;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result 0x%06h", data));
        return;
      end
      want = pending_q.pop_front();
      if (data[15:0] !== want.cost)
        report_mismatch($sformatf("cost %0d, expected %0d", data[15:0], want.cost));
      if (data[16] !== want.rear)
        report_mismatch($sformatf("rear_side %0b, expected %0b", data[16], want.rear));
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  cost_scoreboard sb = new();
  bit  gaps_on = 1'b1;
  int  cycles = 0;

  asymmetric_gaussian_cost dut (.*);

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stall bursts, checks at the rising edge
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        m_axis_tready = 1'b0;
        stall = $urandom_range(0, 5);
      end else begin
        m_axis_tready = 1'b1;
      end
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic configure(logic [15:0] a, logic [15:0] f, logic [15:0] s,
                           logic [15:0] r);
    // stop requesting, then let the pipeline drain
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    write_reg(REG_AMPLITUDE, a);
    write_reg(REG_SIGMA_FRONT, f);
    write_reg(REG_SIGMA_SIDE, s);
    write_reg(REG_SIGMA_REAR, r);
  endtask

  // one request; valid stays high between back-to-back requests
  task automatic send_request(logic [23:0] cx, logic [23:0] cy, logic [23:0] px,
                              logic [23:0] py, logic [14:0] hd);
    int gap;
    gap = (gaps_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {1'b0, hd, py, px, cy, cx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(cx, cy, px, py, hd);
  endtask

  task automatic send_random();
    logic [23:0] px, py, cx, cy;
    logic [14:0] hd;
    int reach;
    px = 24'($urandom);
    py = 24'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: reach = 4096;
      3, 4, 5: reach = 16384;
      6, 7:    reach = 65536;
      default: reach = 0;
    endcase
    if (reach == 0) begin
      cx = 24'($urandom);
      cy = 24'($urandom);
    end else begin
      cx = px + 24'($urandom_range(0, 2 * reach) - reach);
      cy = py + 24'($urandom_range(0, 2 * reach) - reach);
    end
    if ($urandom_range(0, 9) == 0) hd = 15'($urandom);
    else hd = 15'($urandom_range(0, 2 * 12868) - 12868);
    send_request(cx, cy, px, py, hd);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset registers, corner offsets and headings
    send_request(24'd100, 24'd200, 24'd100, 24'd200, 15'd0);       // cell on person
    send_request(24'd0, 24'd0, 24'd0, 24'd0, 15'sd12868);
    send_request(24'd0, 24'd0, 24'd0, 24'd0, -15'sd12868);
    send_request(24'd0, 24'd0, 24'd0, 24'd0, 15'h3fff);            // beyond pi
    send_request(24'd0, 24'd0, 24'd0, 24'd0, 15'h4000);            // beyond -pi
    send_request(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 15'd0);
    send_request(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 15'h7fff);
    send_request(24'd2048, 24'd0, 24'd0, 24'd0, 15'd0);            // ahead
    send_request(-24'sd2048, 24'd0, 24'd0, 24'd0, 15'd0);          // behind
    send_request(24'd0, 24'd4096, 24'd0, 24'd0, 15'd0);            // to the side
    send_request(24'd0, 24'd4096, 24'd0, 24'd0, 15'sd6434);
    send_request(24'd40000, 24'd0, 24'd0, 24'd0, 15'd0);           // exp underflow
    repeat (230) send_random();

    configure(16'hffff, 16'hffff, 16'd1, 16'hffff);
    send_request(24'd0, 24'd0, 24'd0, 24'd0, 15'd0);
    repeat (240) send_random();

    configure(16'd0, 16'd1, 16'hffff, 16'd1);
    repeat (240) send_random();

    configure(16'd1000, 16'd0, 16'd0, 16'd0);                      // zero sigmas
    send_request(24'd0, 24'd0, 24'd0, 24'd0, 15'd0);
    repeat (240) send_random();

    configure(16'd1000, 16'd8192, 16'd2048, 16'd1024);
    repeat (250) send_random();

    configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    repeat (250) send_random();

    configure(16'd300, 16'd16384, 16'd4096, 16'd2048);
    repeat (100) send_random();
    gaps_on = 1'b0;
    repeat (150) send_random();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
